[design/fbf_pkg.sv]
// shared types and constants for the framebuffer fill engine
// item and result structs, request codes, segment codes, controller states
// no dependencies
package fbf_pkg;

  // request codes
  localparam logic [2:0] REQ_CLEAR   = 3'd0;
  localparam logic [2:0] REQ_FILL    = 3'd1;
  localparam logic [2:0] REQ_OUTLINE = 3'd2;
  localparam logic [2:0] REQ_HLINE   = 3'd3;
  localparam logic [2:0] REQ_VLINE   = 3'd4;
  localparam logic [2:0] REQ_READ    = 3'd5;

  // one command item
  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic signed [11:0] extent_w;
    logic signed [11:0] extent_h;
    logic [15:0]        fill_color;
  } item_t;

  // one result item
  typedef struct packed {
    logic [15:0] pixel_color;
    logic [7:0]  red8;
    logic [7:0]  green8;
    logic [7:0]  blue8;
    logic        read_outside;
  } result_t;

  // which area the draw loop sweeps
  typedef enum logic [2:0] {
    SEG_FULL,
    SEG_RECT,
    SEG_TOP,
    SEG_BOTTOM,
    SEG_LEFT,
    SEG_RIGHT
  } seg_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_SETUP,
    ST_DRAW,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic init;
    logic setup;
    logic step;
    logic rd_issue;
    logic respond;
    seg_t seg;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] req;
    logic       empty;
    logic       last;
  } status_t;

endpackage

[design/fbf_ram.sv]
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module fbf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/fbf_ctrl.sv]
// controller state machine for the framebuffer fill engine
// depends on fbf_pkg
module fbf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output fbf_pkg::ctl_t    ctl,
  input  fbf_pkg::status_t status
);
  import fbf_pkg::*;

  state_t state, state_next;
  seg_t   seg, seg_next;
  logic   booting, booting_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      seg       <= SEG_FULL;
      booting   <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      seg     <= seg_next;
      booting <= booting_next;
      if (ctl.respond) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign cmd_ready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    seg_next     = seg;
    booting_next = booting;
    ctl          = '0;
    ctl.seg      = seg;
    case (state)
      ST_INIT: begin
        // clearing pass: full screen in color zero
        ctl.init   = 1'b1;
        seg_next   = SEG_FULL;
        state_next = ST_SETUP;
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          ctl.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status.req)
          REQ_CLEAR: begin
            seg_next   = SEG_FULL;
            state_next = ST_SETUP;
          end
          REQ_FILL: begin
            seg_next   = SEG_RECT;
            state_next = ST_SETUP;
          end
          REQ_OUTLINE, REQ_HLINE: begin
            seg_next   = SEG_TOP;
            state_next = ST_SETUP;
          end
          REQ_VLINE: begin
            seg_next   = SEG_LEFT;
            state_next = ST_SETUP;
          end
          REQ_READ: begin
            ctl.rd_issue = 1'b1;
            state_next   = ST_DONE;
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_SETUP: begin
        ctl.setup  = 1'b1;
        state_next = ST_DRAW;
      end
      ST_DRAW: begin
        if (!status.empty) begin
          ctl.step = 1'b1;
        end
        if (status.empty || status.last) begin
          if (booting) begin
            booting_next = 1'b0;
            state_next   = ST_IDLE;
          end else if (status.req == REQ_OUTLINE && seg != SEG_RIGHT) begin
            // outline goes top, bottom, left, right
            case (seg)
              SEG_TOP:    seg_next = SEG_BOTTOM;
              SEG_BOTTOM: seg_next = SEG_LEFT;
              default:    seg_next = SEG_RIGHT;
            endcase
            state_next = ST_SETUP;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          ctl.respond = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[design/fbf_datapath.sv]
// datapath: command registers, clipping, pixel sweep counters, frame store
// depends on fbf_pkg and fbf_ram
module fbf_datapath #(
  parameter int SCREEN_W = 128,
  parameter int SCREEN_H = 64
) (
  input  logic             clk,
  input  fbf_pkg::item_t   cmd_item,
  input  fbf_pkg::ctl_t    ctl,
  output fbf_pkg::status_t status,
  output fbf_pkg::result_t rsp_item
);
  import fbf_pkg::*;

  localparam int NPIX = SCREEN_W * SCREEN_H;
  localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int XW   = (SCREEN_W > 1) ? $clog2(SCREEN_W) : 1;
  localparam int YW   = (SCREEN_H > 1) ? $clog2(SCREEN_H) : 1;
  localparam logic signed [15:0] WS = 16'(SCREEN_W);
  localparam logic signed [15:0] HS = 16'(SCREEN_H);

  logic [2:0]         req;
  logic signed [11:0] px, py, pw, ph;
  logic [15:0]        color;

  logic signed [15:0] ex, ey, ew, eh;
  logic signed [15:0] sx, sy, sw, sh;
  logic signed [15:0] xl, yl, xe, ye, xlast_w, ylast_w;
  logic               seg_empty;

  logic [XW-1:0] cx, x_lo, x_last;
  logic [YW-1:0] cy, y_last;
  logic          empty;
  logic          last;
  logic          outside;

  logic [AW-1:0] waddr, raddr;
  logic          re;
  logic [15:0]   rdata;
  result_t       result;

  // command registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req   <= cmd_item.req_type;
      px    <= cmd_item.pos_x;
      py    <= cmd_item.pos_y;
      pw    <= cmd_item.extent_w;
      ph    <= cmd_item.extent_h;
      color <= cmd_item.fill_color;
    end else if (ctl.init) begin
      color <= '0;
    end
  end

  // segment selection and clipping to the screen
  always_comb begin
    ex = {{4{px[11]}}, px};
    ey = {{4{py[11]}}, py};
    ew = {{4{pw[11]}}, pw};
    eh = {{4{ph[11]}}, ph};
    sx = ex;
    sy = ey;
    sw = ew;
    sh = eh;
    case (ctl.seg)
      SEG_FULL: begin
        sx = '0;
        sy = '0;
        sw = WS;
        sh = HS;
      end
      SEG_TOP: begin
        sh = 16'sd1;
      end
      SEG_BOTTOM: begin
        sy = ey + eh - 16'sd1;
        sh = 16'sd1;
      end
      SEG_LEFT: begin
        sw = 16'sd1;
      end
      SEG_RIGHT: begin
        sx = ex + ew - 16'sd1;
        sw = 16'sd1;
      end
      default: begin
      end
    endcase
    xl = (sx < 16'sd0) ? 16'sd0 : sx;
    yl = (sy < 16'sd0) ? 16'sd0 : sy;
    xe = sx + sw;
    ye = sy + sh;
    if (xe > WS) begin
      xe = WS;
    end
    if (ye > HS) begin
      ye = HS;
    end
    xlast_w   = xe - 16'sd1;
    ylast_w   = ye - 16'sd1;
    seg_empty = (xe <= xl) || (ye <= yl);
  end

  // sweep counters, row-major
  always_ff @(posedge clk) begin
    if (ctl.setup) begin
      x_lo   <= xl[XW-1:0];
      cx     <= xl[XW-1:0];
      cy     <= yl[YW-1:0];
      x_last <= xlast_w[XW-1:0];
      y_last <= ylast_w[YW-1:0];
      empty  <= seg_empty;
    end else if (ctl.step) begin
      if (cx == x_last) begin
        cx <= x_lo;
        cy <= cy + YW'(1);
      end else begin
        cx <= cx + XW'(1);
      end
    end
  end

  assign last = (cx == x_last) && (cy == y_last);

  assign status.req   = req;
  assign status.empty = empty;
  assign status.last  = last;

  // frame store addressing
  assign waddr   = AW'(cy) * AW'(SCREEN_W) + AW'(cx);
  assign outside = (px < 12'sd0) || (ex >= WS) || (py < 12'sd0) || (ey >= HS);
  assign raddr   = AW'(py[YW-1:0]) * AW'(SCREEN_W) + AW'(px[XW-1:0]);
  assign re      = ctl.rd_issue && !outside;

  fbf_ram #(
    .WIDTH(16),
    .DEPTH(NPIX)
  ) u_store (
    .clk  (clk),
    .we   (ctl.step),
    .waddr(waddr),
    .wdata(color),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // result formation with bit replication
  always_comb begin
    result = '0;
    if (req == REQ_READ) begin
      if (outside) begin
        result.read_outside = 1'b1;
      end else begin
        result.pixel_color = rdata;
        result.red8        = {rdata[15:11], rdata[15:13]};
        result.green8      = {rdata[10:5], rdata[10:9]};
        result.blue8       = {rdata[4:0], rdata[4:2]};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.respond) begin
      rsp_item <= result;
    end
  end

endmodule

[design/framebuffer_clipped_fill_engine_core.sv]
// framebuffer fill engine top level: one command item in, one result item out
// draw commands go through decode, setup, a sweep and done; outline does setup and a
// sweep for each of its four lines; reads and unused codes go from decode to done
// throughput: one pixel per cycle; one item in flight
// reset: clearing pass zeroes the store, cmd_ready low until it is done
// depends on fbf_pkg, fbf_ctrl, fbf_datapath
module framebuffer_clipped_fill_engine_core #(
  parameter int SCREEN_W = 128,
  parameter int SCREEN_H = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  fbf_pkg::item_t   cmd_item,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output fbf_pkg::result_t rsp_item
);
  import fbf_pkg::*;

  ctl_t    ctl;
  status_t status;

  // sequencing
  fbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .ctl      (ctl),
    .status   (status)
  );

  // clipping, sweep and frame store
  fbf_datapath #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) u_dp (
    .clk     (clk),
    .cmd_item(cmd_item),
    .ctl     (ctl),
    .status  (status),
    .rsp_item(rsp_item)
  );

endmodule

[design/fbf_checker.sv]
// port-level checks for the framebuffer fill engine, bound to the top level
// depends on fbf_pkg and framebuffer_clipped_fill_engine_core
module fbf_checker (
  input logic             clk,
  input logic             rst,
  input logic             cmd_valid,
  input logic             cmd_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input fbf_pkg::result_t rsp_item
);
  import fbf_pkg::*;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
    else $error("result changed while stalled");

  // one item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("item accepted while previous one in flight");

  // an off-screen read carries no color
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.read_outside |->
      rsp_item.pixel_color == 16'd0 && rsp_item.red8 == 8'd0 &&
      rsp_item.green8 == 8'd0 && rsp_item.blue8 == 8'd0)
    else $error("off-screen read returned color");

  // channel expansion matches the stored word
  a_expand: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |->
      rsp_item.red8 == {rsp_item.pixel_color[15:11], rsp_item.pixel_color[15:13]} &&
      rsp_item.green8 == {rsp_item.pixel_color[10:5], rsp_item.pixel_color[10:9]} &&
      rsp_item.blue8 == {rsp_item.pixel_color[4:0], rsp_item.pixel_color[4:2]})
    else $error("channel expansion mismatch");

endmodule

bind framebuffer_clipped_fill_engine_core fbf_checker u_fbf_checker (.*);
